// File: rtl/qte_pkg.sv
`timescale 1ns / 1ps
// Package for the quaternion to Euler angle converter.
// Holds widths, fixed-point constants, the arctangent table and helper functions.
// Depends on nothing.
package qte_pkg;

  // Number of CORDIC micro-rotations; the table covers at most 24.
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_TAB_LEN = 24;
  localparam int CORDIC_STEPS =
    (CORDIC_ITERATIONS > ANGLE_TAB_LEN) ? ANGLE_TAB_LEN : CORDIC_ITERATIONS;

  // Widths: quaternion part, CORDIC input vector, CORDIC datapath, angle accumulator.
  localparam int QW = 16;
  localparam int VW = 34;
  localparam int CW = 36;
  localparam int ZW = 20;
  localparam int AW = 17;
  localparam int PW = 29;
  localparam int MW = 28;

  // Square root unit: one result bit per stage.
  localparam int SQW = 58;
  localparam int SQRT_STEPS = 29;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic signed [VW-1:0] ONE_Q28 = VW'(64'sd268435456);
  localparam logic [SQW-1:0] ONE_Q56 = SQW'(1) << (2 * MW);
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
  localparam logic signed [AW-1:0] HALF_PI_Q13 = AW'(12868);
  localparam logic signed [AW-1:0] PI_Q13 = AW'(25736);

  // round(atan(2^-i) * 2^16)
  localparam logic signed [ZW-1:0] ATAN_TAB [ANGLE_TAB_LEN] = '{
    ZW'(51472), ZW'(30386), ZW'(16055), ZW'(8150), ZW'(4091), ZW'(2047), ZW'(1024),
    ZW'(512), ZW'(256), ZW'(128), ZW'(64), ZW'(32), ZW'(16), ZW'(8), ZW'(4), ZW'(2),
    ZW'(1), ZW'(0), ZW'(0), ZW'(0), ZW'(0), ZW'(0), ZW'(0), ZW'(0)
  };

  // One beat as it passes from the front to the back.
  typedef struct packed {
    logic signed [VW-1:0] roll_x;
    logic signed [VW-1:0] roll_y;
    logic signed [VW-1:0] yaw_x;
    logic signed [VW-1:0] yaw_y;
    logic signed [VW-1:0] pitch_y;
    logic [PW-1:0]        pitch_x;
    logic                 sat_pos;
    logic                 sat_neg;
  } qte_item_t;

  // Remainder and partial root of the digit-by-digit square root.
  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
  } qte_sqrt_t;

  // One step of the restoring square root with trial bit bitv.
  function automatic qte_sqrt_t qte_sqrt_step(qte_sqrt_t a, logic [SQW-1:0] bitv);
    qte_sqrt_t r;
    logic [SQW-1:0] trial;
    trial = a.res + bitv;
    if (a.n >= trial) begin
      r.n = a.n - trial;
      r.res = (a.res >> 1) + bitv;
    end else begin
      r.n = a.n;
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  // Symmetric clamp to +-lim.
  function automatic logic signed [AW-1:0] qte_clamp(logic signed [AW-1:0] v,
                                                     logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/qte_in_if.sv
`timescale 1ns / 1ps
// Input channel of the converter: one quaternion per beat.
// Depends on nothing.
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, output quat_w, output quat_x, output quat_y,
                 output quat_z, input ready);
  modport sink(input valid, input quat_w, input quat_x, input quat_y,
               input quat_z, output ready);
endinterface

// File: rtl/qte_out_if.sv
`timescale 1ns / 1ps
// Output channel of the converter: roll, pitch and yaw per beat.
// Depends on nothing.
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  modport source(output valid, output roll_angle, output pitch_angle,
                 output yaw_angle, input ready);
  modport sink(input valid, input roll_angle, input pitch_angle,
               input yaw_angle, output ready);
endinterface

// File: rtl/quaternion_to_euler.sv
`timescale 1ns / 1ps
// From acceptance to result a beat passes 33 front stages (products, sums,
// square, remainder, 29 square root bits), the queue storage, and a CORDIC
// stage per iteration plus pre-rotation and output register; every stage is
// a pipeline register. Throughput: one quaternion per cycle when not stalled.
// Reset clears the valid bits, queue pointers and fill level; no other state.
module quaternion_to_euler
  import qte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  qte_in_if.sink    quat,
  qte_out_if.source angles
);

  logic      f_valid, f_ready, b_valid, b_ready;
  qte_item_t f_item, b_item;

  // Front: accepts beats and prepares the CORDIC vectors.
  qte_front u_front (
    .clk(clk), .rst(rst), .quat(quat),
    .item_valid(f_valid), .item(f_item), .item_ready(f_ready)
  );

  qte_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_item(f_item), .in_ready(f_ready),
    .out_valid(b_valid), .out_item(b_item), .out_ready(b_ready)
  );

  // Back: angle computation and result register.
  qte_back u_back (
    .clk(clk), .rst(rst),
    .item_valid(b_valid), .item(b_item), .item_ready(b_ready),
    .angles(angles)
  );

endmodule

// File: rtl/qte_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC in vectoring mode: atan2(y, x) in Q3.13, unclamped.
// Depends on qte_pkg.
module qte_cordic
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  output logic signed [AW-1:0] angle
);

  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs [CORDIC_STEPS+1];
  logic                 zf [CORDIC_STEPS+1];

  logic signed [CW-1:0] xe, ye, x0c, y0c;
  logic signed [ZW-1:0] z0c;
  logic signed [ZW-1:0] zr;

  // Quarter turn toward the positive x axis when x is negative.
  always_comb begin
    xe = CW'(x_in);
    ye = CW'(y_in);
    if (xe < 0) begin
      if (ye >= 0) begin
        x0c = ye;
        y0c = -xe;
        z0c = HALF_PI_Q16;
      end else begin
        x0c = -ye;
        y0c = xe;
        z0c = -HALF_PI_Q16;
      end
    end else begin
      x0c = xe;
      y0c = ye;
      z0c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= x0c;
      ys[0] <= y0c;
      zs[0] <= z0c;
      zf[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end
        zf[i+1] <= zf[i];
      end
    end
  end

  // Round Q.16 to Q.13; the zero vector gives zero.
  assign zr = (zs[CORDIC_STEPS] + ZW'(4)) >>> 3;
  assign angle = zf[CORDIC_STEPS] ? '0 : zr[AW-1:0];

endmodule

// File: rtl/qte_front.sv
`timescale 1ns / 1ps
// Front of the converter: products, sums, pitch saturation and the
// pipelined square root of 1 - s*s. Depends on qte_pkg and qte_in_if.
module qte_front
  import qte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  qte_in_if.sink    quat,
  output logic      item_valid,
  output qte_item_t item,
  input  logic      item_ready
);

  localparam int NSTAGE = 4 + SQRT_STEPS;

  logic en;
  logic [NSTAGE-1:0] vld;

  logic signed [2*QW-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  logic signed [VW-1:0] roll_x_c, roll_y_c, yaw_x_c, yaw_y_c, s_c, s_abs;
  qte_item_t it2, it3, it4;
  logic [MW-1:0] mag2;
  logic [2*MW-1:0] sq3;
  qte_sqrt_t sq4;
  qte_item_t sit [SQRT_STEPS];
  qte_sqrt_t sst [SQRT_STEPS];

  // The whole front moves together unless its last beat is held up.
  assign en = !item_valid || item_ready;
  assign quat.ready = en;
  assign item_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], quat.valid};
    end
  end

  // Stage 1: all products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat.quat_w * quat.quat_x;
      p_yz <= quat.quat_y * quat.quat_z;
      p_xx <= quat.quat_x * quat.quat_x;
      p_yy <= quat.quat_y * quat.quat_y;
      p_wz <= quat.quat_w * quat.quat_z;
      p_xy <= quat.quat_x * quat.quat_y;
      p_zz <= quat.quat_z * quat.quat_z;
      p_wy <= quat.quat_w * quat.quat_y;
      p_zx <= quat.quat_z * quat.quat_x;
    end
  end

  // Stage 2: vectors for the three angles and classification of s.
  always_comb begin
    roll_y_c = (VW'(p_wx) + VW'(p_yz)) <<< 1;
    roll_x_c = ONE_Q28 - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
    yaw_y_c = (VW'(p_wz) + VW'(p_xy)) <<< 1;
    yaw_x_c = ONE_Q28 - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
    s_c = (VW'(p_wy) - VW'(p_zx)) <<< 1;
    s_abs = s_c[VW-1] ? -s_c : s_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2.roll_x <= roll_x_c;
      it2.roll_y <= roll_y_c;
      it2.yaw_x <= yaw_x_c;
      it2.yaw_y <= yaw_y_c;
      it2.pitch_y <= s_c;
      it2.pitch_x <= '0;
      it2.sat_pos <= s_c >= ONE_Q28;
      it2.sat_neg <= s_c <= -ONE_Q28;
      mag2 <= s_abs[MW-1:0];
    end
  end

  // Stage 3: square of |s|; stage 4: remainder 1 - s*s in Q.56.
  always_ff @(posedge clk) begin
    if (en) begin
      it3 <= it2;
      sq3 <= mag2 * mag2;
      it4 <= it3;
      sq4.n <= ONE_Q56 - SQW'(sq3);
      sq4.res <= '0;
    end
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    qte_sqrt_t sin;
    qte_item_t iin;
    if (j == 0) begin : g_first
      assign sin = sq4;
      assign iin = it4;
    end else begin : g_rest
      assign sin = sst[j-1];
      assign iin = sit[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sit[j] <= iin;
        sst[j] <= qte_sqrt_step(sin, SQW'(1) << (2 * (SQRT_STEPS - 1 - j)));
      end
    end
  end

  always_comb begin
    item = sit[SQRT_STEPS-1];
    item.pitch_x = sst[SQRT_STEPS-1].res[PW-1:0];
  end

`ifndef SYNTHESIS
  // A beat refused by the queue stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_ready) |=> (item_valid && $stable(item)))
    else $error("front beat changed while stalled");
`endif

endmodule

// File: rtl/qte_queue.sv
`timescale 1ns / 1ps
// Short queue that decouples the front from the back.
// Depends on qte_pkg.
module qte_queue
  import qte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  qte_item_t in_item,
  output logic      in_ready,
  output logic      out_valid,
  output qte_item_t out_item,
  input  logic      out_ready
);

  qte_item_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0] count;
  logic push, pop;

  assign in_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue fill level wrong after a pop");
`endif

endmodule

// File: rtl/qte_back.sv
`timescale 1ns / 1ps
// Back of the converter: three CORDIC lanes, pitch saturation, clamping and
// the output register. Depends on qte_pkg, qte_out_if and qte_cordic.
module qte_back
  import qte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  qte_item_t item,
  output logic      item_ready,
  qte_out_if.source angles
);

  localparam int NSTAGE = CORDIC_STEPS + 2;

  logic en;
  logic [NSTAGE-1:0] vld;
  logic [CORDIC_STEPS:0][1:0] sat_pipe;
  logic signed [AW-1:0] roll_c, pitch_c, yaw_c;
  logic signed [AW-1:0] roll_cl, pitch_cl, yaw_cl, pitch_sel;

  assign en = !angles.valid || angles.ready;
  assign item_ready = en;
  assign angles.valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], item_valid};
    end
  end

  // Saturation flags travel beside the pitch lane.
  always_ff @(posedge clk) begin
    if (en) begin
      sat_pipe <= {sat_pipe[CORDIC_STEPS-1:0], {item.sat_pos, item.sat_neg}};
    end
  end

  qte_cordic u_roll (
    .clk(clk), .en(en), .x_in(item.roll_x), .y_in(item.roll_y), .angle(roll_c)
  );
  qte_cordic u_pitch (
    .clk(clk), .en(en), .x_in(VW'(item.pitch_x)), .y_in(item.pitch_y), .angle(pitch_c)
  );
  qte_cordic u_yaw (
    .clk(clk), .en(en), .x_in(item.yaw_x), .y_in(item.yaw_y), .angle(yaw_c)
  );

  // Clamp, and force pitch to a quarter turn when |s| reached one.
  always_comb begin
    roll_cl = qte_clamp(roll_c, PI_Q13);
    yaw_cl = qte_clamp(yaw_c, PI_Q13);
    pitch_cl = qte_clamp(pitch_c, HALF_PI_Q13);
    priority if (sat_pipe[CORDIC_STEPS][1]) begin
      pitch_sel = HALF_PI_Q13;
    end else if (sat_pipe[CORDIC_STEPS][0]) begin
      pitch_sel = -HALF_PI_Q13;
    end else begin
      pitch_sel = pitch_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles.roll_angle <= roll_cl[15:0];
      angles.pitch_angle <= pitch_sel[14:0];
      angles.yaw_angle <= yaw_cl[15:0];
    end
  end

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> (angles.pitch_angle <= 15'sd12868 && angles.pitch_angle >= -15'sd12868
                      && angles.roll_angle <= 16'sd25736 && angles.roll_angle >= -16'sd25736
                      && angles.yaw_angle <= 16'sd25736 && angles.yaw_angle >= -16'sd25736))
    else $error("angle outside its range");
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> (vld == $past(vld)))
    else $error("back pipeline moved while stalled");
`endif

endmodule
